// ===== hw/rtl/mtc_pkg.sv =====
package mtc_pkg;

  localparam int MTC_ENTRIES = 64;
  localparam int MTC_PADDR_W = 3;
  localparam int MTC_PDATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_QDISC_MAJOR = 1'b0;

  localparam logic [1:0] FN_CLASSIFY = 2'd0;
  localparam logic [1:0] FN_WRITE    = 2'd1;
  localparam logic [1:0] FN_DELETE   = 2'd2;
  localparam logic [1:0] FN_QUERY    = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOMATCH = 2'd1;
  localparam logic [1:0] STAT_INVALID = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  typedef struct packed {
    logic        vld;
    logic [31:0] mark;
    logic [31:0] cls;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ACT,
    ST_RESP
  } state_t;

endpackage

// ===== hw/rtl/mtc_ram.sv =====
module mtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mtc_apb.sv =====
module mtc_apb
  import mtc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [MTC_PADDR_W-1:0] paddr,
  input  logic [MTC_PDATA_W-1:0] pwdata,
  output logic [MTC_PDATA_W-1:0] prdata,
  output logic                   pready,
  output logic [15:0]            qdisc_major
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_QDISC_MAJOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      qdisc_major <= 16'd0;
    end else if (wr_en) begin
      qdisc_major <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_QDISC_MAJOR) begin
      prdata = {16'd0, qdisc_major};
    end else begin
      prdata = '0;
    end
  end

endmodule

// ===== hw/rtl/mtc_engine.sv =====
module mtc_engine
  import mtc_pkg::*;
#(
  parameter int TABLE_ENTRIES = MTC_ENTRIES,
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         qdisc_major,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic [31:0]         mark,
  input  logic [31:0]         new_class,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic [31:0]         class_id,
  output logic                ram_we,
  output logic [IW-1:0]       ram_waddr,
  output entry_t              ram_wdata,
  output logic                ram_re,
  output logic [IW-1:0]       ram_raddr,
  input  entry_t              ram_rdata
);

  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  state_t state, state_next;

  logic [1:0]    req_func;
  logic [31:0]   req_mark;
  logic [31:0]   req_class;
  logic          table_created;
  logic [IW-1:0] scan_addr;
  logic          issue_on;
  logic          rd_pend;
  logic [IW-1:0] rd_idx;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [31:0]   hit_class;
  logic          free_ok;
  logic [IW-1:0] free_idx;
  logic [1:0]    res_status;
  logic [31:0]   res_class;

  logic          accept;
  logic          fast;
  logic [1:0]    fast_status;
  logic [31:0]   fast_class;
  logic          legacy_ok;
  logic          hit_now;
  logic          scan_done;
  logic [1:0]    act_status;
  logic [31:0]   act_class;
  logic          out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign hit_now  = rd_pend && ram_rdata.vld && (ram_rdata.mark == req_mark);
  assign scan_done = rd_pend && (hit_now || rd_idx == LAST);
  assign legacy_ok = (mark != 32'd0) &&
                     ((mark[31:16] == 16'd0) || (mark[31:16] == qdisc_major));

  // requests settled without a table search
  always_comb begin
    fast        = 1'b0;
    fast_status = STAT_NOMATCH;
    fast_class  = 32'd0;
    case (func)
      FN_CLASSIFY: begin
        if (!table_created) begin
          fast = 1'b1;
          if (legacy_ok) begin
            fast_status = STAT_OK;
            fast_class  = mark;
          end
        end
      end
      FN_WRITE: begin
        if (mark == 32'd0) begin
          fast        = 1'b1;
          fast_status = STAT_INVALID;
        end
      end
      FN_DELETE: begin
        if (!table_created) begin
          fast        = 1'b1;
          fast_status = STAT_INVALID;
        end
      end
      default: begin
        fast = !table_created;
      end
    endcase
  end

  always_comb begin
    act_status = STAT_NOMATCH;
    act_class  = 32'd0;
    case (req_func)
      FN_WRITE: begin
        if (hit || free_ok) begin
          act_status = STAT_OK;
          act_class  = req_class;
        end else begin
          act_status = STAT_FULL;
        end
      end
      FN_DELETE: begin
        if (hit) begin
          act_status = STAT_OK;
          act_class  = hit_class;
        end else begin
          act_status = STAT_INVALID;
        end
      end
      default: begin
        if (hit) begin
          act_status = STAT_OK;
          act_class  = hit_class;
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (scan_addr == LAST) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = fast ? ST_RESP : ST_SCAN;
      ST_SCAN:  if (scan_done) state_next = ST_ACT;
      ST_ACT:   state_next = ST_RESP;
      ST_RESP:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    ram_re    = (state == ST_SCAN) && issue_on;
    ram_raddr = scan_addr;
    ram_we    = 1'b0;
    ram_waddr = scan_addr;
    ram_wdata = '0;
    case (state)
      ST_CLEAR: ram_we = 1'b1;
      ST_ACT: begin
        if (req_func == FN_WRITE && (hit || free_ok)) begin
          ram_we    = 1'b1;
          ram_waddr = hit ? hit_idx : free_idx;
          ram_wdata = '{vld: 1'b1, mark: req_mark, cls: req_class};
        end else if (req_func == FN_DELETE && hit) begin
          ram_we    = 1'b1;
          ram_waddr = hit_idx;
          ram_wdata = '{vld: 1'b0, mark: req_mark, cls: hit_class};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      scan_addr     <= '0;
      issue_on      <= 1'b0;
      rd_pend       <= 1'b0;
      hit           <= 1'b0;
      free_ok       <= 1'b0;
      table_created <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      // in RESP a taken word is replaced below
      if (out_valid && out_ready && state != ST_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (scan_addr != LAST) begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            scan_addr <= '0;
            issue_on  <= 1'b1;
            rd_pend   <= 1'b0;
            hit       <= 1'b0;
            free_ok   <= 1'b0;
            if (func == FN_WRITE && mark != 32'd0) begin
              table_created <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= ram_re;
          if (ram_re) begin
            if (scan_addr == LAST) begin
              issue_on <= 1'b0;
            end else begin
              scan_addr <= scan_addr + 1'b1;
            end
          end
          if (hit_now) begin
            hit <= 1'b1;
          end
          if (rd_pend && !ram_rdata.vld && !free_ok) begin
            free_ok <= 1'b1;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func   <= func;
      req_mark   <= mark;
      req_class  <= new_class;
      res_status <= fast_status;
      res_class  <= fast_class;
    end
    if (state == ST_SCAN) begin
      if (ram_re) begin
        rd_idx <= scan_addr;
      end
      if (hit_now) begin
        hit_idx   <= rd_idx;
        hit_class <= ram_rdata.cls;
      end
      if (rd_pend && !ram_rdata.vld && !free_ok) begin
        free_idx <= rd_idx;
      end
    end
    if (state == ST_ACT) begin
      res_status <= act_status;
      res_class  <= act_class;
    end
    if (state == ST_RESP && out_free) begin
      status   <= res_status;
      class_id <= res_class;
    end
  end

  // table is only written while no read is in flight
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_miss_zero_class: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> class_id == 32'd0)
    else $error("non-zero class id on a miss");

  a_write_creates: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACT && req_func == FN_WRITE |-> table_created)
    else $error("table write without table created");

  a_result_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_RESP)
    else $error("result word raised outside response state");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !in_ready)
    else $error("word accepted during clearing pass");

endmodule

// ===== hw/rtl/mark_to_class_classifier.sv =====
// Exact-match mark to class classifier. Requests (classify, write, delete,
// query) are taken one at a time on the in channel and each gives one result
// word on the out channel, held in an output register so the next request is
// taken while a result waits. The table sits in a synchronous RAM with
// separate read and write ports that is searched one entry per cycle: a
// searching request is accepted, then scans with early stop on a hit, then
// passes the update state and the result state; requests settled without a
// search (legacy classify, write of mark zero, delete or query before the
// first write) go from accept straight to the result state. After reset a
// clearing pass empties the table, with in_ready low; qdisc_major may be
// written meanwhile.
module mark_to_class_classifier
  import mtc_pkg::*;
#(
  parameter int TABLE_ENTRIES = MTC_ENTRIES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [MTC_PADDR_W-1:0] paddr,
  input  logic [MTC_PDATA_W-1:0] pwdata,
  output logic [MTC_PDATA_W-1:0] prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             func,
  input  logic [31:0]            mark,
  input  logic [31:0]            new_class,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic [31:0]            class_id
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [15:0]   qdisc_major;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  mtc_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .qdisc_major (qdisc_major)
  );

  mtc_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .qdisc_major (qdisc_major),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .mark        (mark),
    .new_class   (new_class),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .class_id    (class_id),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  mtc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
